// ===== rtl/fsv_pkg.sv =====
package fsv_pkg;

  localparam int OUT_BITS = 16;

  typedef logic [7:0]          char_t;
  typedef logic [1:0]          status_t;
  typedef logic [OUT_BITS-1:0] out_word_t;

  localparam status_t STATUS_ACCEPT  = 2'd0;
  localparam status_t STATUS_INVALID = 2'd1;
  localparam status_t STATUS_END     = 2'd2;

  localparam out_word_t OUT_MAX = '1;

  localparam char_t CH_PERCENT = 8'h25;
  localparam char_t CH_S       = 8'h73;
  localparam char_t CH_STAR    = 8'h2A;
  localparam char_t CH_DOT     = 8'h2E;
  localparam char_t CH_H       = 8'h68;
  localparam char_t CH_L       = 8'h6C;
  localparam char_t CH_UPPER_L = 8'h4C;
  localparam char_t CH_Z       = 8'h7A;
  localparam char_t CH_J       = 8'h6A;
  localparam char_t CH_T       = 8'h74;
  localparam char_t CH_MINUS   = 8'h2D;
  localparam char_t CH_PLUS    = 8'h2B;
  localparam char_t CH_SPACE   = 8'h20;
  localparam char_t CH_HASH    = 8'h23;
  localparam char_t CH_ZERO    = 8'h30;
  localparam char_t CH_NINE    = 8'h39;

  typedef struct packed {
    status_t   status;
    out_word_t end_position;
    out_word_t specifier_count;
    logic      run_last;
  } result_t;

endpackage

// ===== rtl/fsv_in_if.sv =====
interface fsv_in_if
  import fsv_pkg::*;
();
  logic  valid;
  logic  ready;
  char_t char_byte;
  logic  is_last;

  modport source (output valid, output char_byte, output is_last, input ready);
  modport sink (input valid, input char_byte, input is_last, output ready);
endinterface

// ===== rtl/fsv_out_if.sv =====
interface fsv_out_if
  import fsv_pkg::*;
();
  logic      valid;
  logic      ready;
  status_t   status;
  out_word_t end_position;
  out_word_t specifier_count;
  logic      run_last;

  modport source (
    output valid, output status, output end_position, output specifier_count,
    output run_last, input ready
  );
  modport sink (
    input valid, input status, input end_position, input specifier_count,
    input run_last, output ready
  );
endinterface

// ===== rtl/format_specifier_validator_unit.sv =====
// Format string checker for printf-style strings, one byte per transfer.
// The input channel carries one byte of the string and a mark on its final
// byte. The result channel carries a report for every accepted %s specifier
// (status accept, position just past the s, running count), a report for an
// invalid specifier (after which bytes are dropped until the final byte), and
// an end report on the final byte unless an error was reported. A final byte
// may give two reports, accept then end; run_last marks the last of them.
// A byte goes into an input stage register, is parsed there and its reports are
// written into a two-entry result buffer, from which the result channel reads.
// The block takes one byte per cycle while the buffer has room for its reports;
// a byte giving two reports holds the input stage only while the buffer lacks
// room for both.
// Reset empties the stage and the buffer and returns the parser to plain text
// with position and count at zero; the final byte of each string resets the parser alike.
// When the receiver stalls, the buffer holds up to two reports and the stage
// one byte, after which ready drops on the input channel.
module format_specifier_validator_unit
  import fsv_pkg::*;
#(
  parameter int POSITION_BITS = 16
) (
  input logic  clk,
  input logic  rst_n,
  fsv_in_if.sink    in_chan,
  fsv_out_if.source out_chan
);

  localparam int WIDE_BITS = (POSITION_BITS > OUT_BITS) ? POSITION_BITS : OUT_BITS;

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [WIDE_BITS-1:0]     wide_t;

  typedef enum logic [3:0] {
    PH_TEXT   = 4'd0,
    PH_PCT    = 4'd1,
    PH_FLAGS  = 4'd2,
    PH_WIDTH  = 4'd3,
    PH_DOT    = 4'd4,
    PH_PREC   = 4'd5,
    PH_H1     = 4'd6,
    PH_H2     = 4'd7,
    PH_L1     = 4'd8,
    PH_L2     = 4'd9,
    PH_LEN    = 4'd10,
    PH_ERR    = 4'd11,
    PH_ACCEPT = 4'd12
  } phase_t;

  function automatic phase_t spec_next(phase_t ph, char_t c);
    logic is_digit;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    if (c == CH_S) begin
      return PH_ACCEPT;
    end
    if (c == CH_STAR) begin
      return PH_ERR;
    end
    if ((ph <= PH_FLAGS) && (c == CH_MINUS || c == CH_PLUS || c == CH_SPACE ||
                             c == CH_HASH || c == CH_ZERO)) begin
      return PH_FLAGS;
    end
    if (is_digit) begin
      if (ph <= PH_WIDTH) begin
        return PH_WIDTH;
      end
      if (ph == PH_DOT || ph == PH_PREC) begin
        return PH_PREC;
      end
      return PH_ERR;
    end
    if (c == CH_DOT) begin
      return (ph <= PH_WIDTH) ? PH_DOT : PH_ERR;
    end
    if (c == CH_H) begin
      if (ph <= PH_PREC) begin
        return PH_H1;
      end
      return (ph == PH_H1) ? PH_H2 : PH_ERR;
    end
    if (c == CH_L) begin
      if (ph <= PH_H2) begin
        return PH_L1;
      end
      return (ph == PH_L1) ? PH_L2 : PH_ERR;
    end
    if (c == CH_UPPER_L || c == CH_Z || c == CH_J || c == CH_T) begin
      return (ph <= PH_L2) ? PH_LEN : PH_ERR;
    end
    return PH_ERR;
  endfunction

  function automatic out_word_t clamp_out(pos_t v);
    wide_t w;
    w = wide_t'(v);
    return (w > wide_t'(OUT_MAX)) ? OUT_MAX : w[OUT_BITS-1:0];
  endfunction

  function automatic pos_t sat_inc(pos_t v);
    return (v == '1) ? v : v + pos_t'(1);
  endfunction

  // Input stage.
  logic   stage_valid_r, stage_valid_nxt;
  char_t  stage_char_r;
  logic   stage_last_r;

  // Parser state.
  phase_t phase_r, phase_nxt;
  pos_t   pos_r, pos_nxt;
  pos_t   cnt_r, cnt_nxt;

  // Result buffer.
  result_t    buf_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  logic       in_fire;
  logic       out_pop;
  logic       stage_fire;
  logic [1:0] free_slots;
  logic [1:0] n_res;
  result_t    res0, res1;

  logic       main_valid, end_valid;
  result_t    main_res, end_res;
  pos_t       pos_inc, cnt_inc;
  phase_t     ph, r;

  assign out_pop    = out_chan.valid && out_chan.ready;
  assign free_slots = 2'd2 - count_r + {1'b0, out_pop};
  assign stage_fire = stage_valid_r && (n_res <= free_slots);
  assign in_chan.ready = !stage_valid_r || stage_fire;
  assign in_fire    = in_chan.valid && in_chan.ready;

  always_comb begin
    pos_inc    = sat_inc(pos_r);
    cnt_inc    = sat_inc(cnt_r);
    ph         = phase_r;
    r          = PH_ERR;
    cnt_nxt    = cnt_r;
    main_valid = 1'b0;
    main_res   = '0;
    end_valid  = 1'b0;
    end_res    = '0;

    if (phase_r == PH_ERR) begin
      ph = PH_ERR;
    end else if (phase_r == PH_TEXT) begin
      ph = (stage_char_r == CH_PERCENT && !stage_last_r) ? PH_PCT : PH_TEXT;
    end else if (phase_r == PH_PCT && stage_char_r == CH_PERCENT) begin
      ph = PH_TEXT;
    end else begin
      r = spec_next(phase_r, stage_char_r);
      if (r == PH_ACCEPT) begin
        cnt_nxt                  = cnt_inc;
        main_valid               = 1'b1;
        main_res.status          = STATUS_ACCEPT;
        main_res.end_position    = clamp_out(pos_inc);
        main_res.specifier_count = clamp_out(cnt_inc);
        ph                       = PH_TEXT;
      end else if (r == PH_ERR || stage_last_r) begin
        main_valid               = 1'b1;
        main_res.status          = STATUS_INVALID;
        main_res.specifier_count = clamp_out(cnt_r);
        ph                       = PH_ERR;
      end else begin
        ph = r;
      end
    end

    if (stage_last_r && ph != PH_ERR) begin
      end_valid               = 1'b1;
      end_res.status          = STATUS_END;
      end_res.end_position    = clamp_out(pos_inc);
      end_res.specifier_count = clamp_out(cnt_nxt);
    end

    if (stage_last_r) begin
      phase_nxt = PH_TEXT;
      pos_nxt   = '0;
      cnt_nxt   = '0;
    end else begin
      phase_nxt = ph;
      pos_nxt   = pos_inc;
    end

    n_res = {1'b0, main_valid} + {1'b0, end_valid};
    res0  = main_valid ? main_res : end_res;
    res1  = end_res;
    res0.run_last = (n_res == 2'd1);
    res1.run_last = 1'b1;
  end

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (in_fire) begin
      stage_valid_nxt = 1'b1;
    end else if (stage_fire) begin
      stage_valid_nxt = 1'b0;
    end
    wr_ptr_nxt = stage_fire ? (wr_ptr_r ^ n_res[0]) : wr_ptr_r;
    rd_ptr_nxt = out_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + (stage_fire ? n_res : 2'd0) - {1'b0, out_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      phase_r       <= PH_TEXT;
      pos_r         <= '0;
      cnt_r         <= '0;
      wr_ptr_r      <= 1'b0;
      rd_ptr_r      <= 1'b0;
      count_r       <= 2'd0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      wr_ptr_r      <= wr_ptr_nxt;
      rd_ptr_r      <= rd_ptr_nxt;
      count_r       <= count_nxt;
      if (stage_fire) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_char_r <= in_chan.char_byte;
      stage_last_r <= in_chan.is_last;
    end
    if (stage_fire && n_res != 2'd0) begin
      buf_r[wr_ptr_r] <= res0;
    end
    if (stage_fire && n_res == 2'd2) begin
      buf_r[!wr_ptr_r] <= res1;
    end
  end

  assign out_chan.valid           = (count_r != 2'd0);
  assign out_chan.status          = buf_r[rd_ptr_r].status;
  assign out_chan.end_position    = buf_r[rd_ptr_r].end_position;
  assign out_chan.specifier_count = buf_r[rd_ptr_r].specifier_count;
  assign out_chan.run_last        = buf_r[rd_ptr_r].run_last;

  // The buffer never holds more than its two entries.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("result buffer overflow");

  // A report that is not the last of its byte always has its partner queued.
  a_pair_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.run_last) |-> (count_r == 2'd2))
    else $error("first report of a pair queued alone");

  // The final byte of a string returns the parser to its reset state.
  a_string_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_fire && stage_last_r) |=> (phase_r == PH_TEXT && pos_r == '0 && cnt_r == '0))
    else $error("parser state not cleared after final byte");

  // Bytes after an error give no reports.
  a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_valid_r && phase_r == PH_ERR) |-> (n_res == 2'd0))
    else $error("report produced while skipping after an error");

endmodule

// ===== verif/tb_format_specifier_validator_unit.sv =====
`timescale 1ns / 1ps

module tb_format_specifier_validator_unit
  import fsv_pkg::*;
();

  localparam int RANDOM_ITEMS = 1500;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  typedef enum logic [3:0] {
    SEEK_TEXT,
    SAW_PERCENT,
    IN_FLAGS,
    IN_WIDTH,
    SAW_DOT,
    IN_PRECISION,
    SAW_H,
    SAW_HH,
    SAW_L,
    SAW_LL,
    SAW_LENGTH,
    SKIP_TO_END,
    SPEC_DONE
  } spec_phase_t;

  localparam char_t FLAG_CHARS[5] = '{CH_MINUS, CH_PLUS, CH_SPACE, CH_HASH, CH_ZERO};
  localparam char_t LENGTH_CHARS[4] = '{CH_UPPER_L, CH_Z, CH_J, CH_T};

  logic clk;
  logic rst_n;

  fsv_in_if in_if ();
  fsv_out_if out_if ();

  format_specifier_validator_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  spec_phase_t spec_phase = SEEK_TEXT;
  out_word_t   scan_position = '0;
  out_word_t   spec_total = '0;
  result_t     pending_reports[$];
  int unsigned live_bytes;
  int unsigned fail_count;
  int unsigned cycle_count;
  bit          gaps_on = 1'b1;
  bit          hold_request = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int roll;
    if (!gaps_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic out_word_t sat_inc(out_word_t v);
    return (v == OUT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic result_t make_report(status_t status, out_word_t position);
    result_t r;
    r.status = status;
    r.end_position = position;
    r.specifier_count = spec_total;
    r.run_last = 1'b0;
    return r;
  endfunction

  function automatic spec_phase_t next_phase(spec_phase_t ph, char_t c);
    logic is_digit;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    if (c == CH_S) return SPEC_DONE;
    if (c == CH_STAR) return SKIP_TO_END;
    if (ph <= IN_FLAGS && (c inside {CH_MINUS, CH_PLUS, CH_SPACE, CH_HASH, CH_ZERO}))
      return IN_FLAGS;
    if (is_digit) begin
      if (ph <= IN_WIDTH) return IN_WIDTH;
      if (ph == SAW_DOT || ph == IN_PRECISION) return IN_PRECISION;
      return SKIP_TO_END;
    end
    if (c == CH_DOT) return (ph <= IN_WIDTH) ? SAW_DOT : SKIP_TO_END;
    if (c == CH_H) begin
      if (ph <= IN_PRECISION) return SAW_H;
      return (ph == SAW_H) ? SAW_HH : SKIP_TO_END;
    end
    if (c == CH_L) begin
      if (ph <= SAW_HH) return SAW_L;
      return (ph == SAW_L) ? SAW_LL : SKIP_TO_END;
    end
    if (c inside {CH_UPPER_L, CH_Z, CH_J, CH_T})
      return (ph <= SAW_LL) ? SAW_LENGTH : SKIP_TO_END;
    return SKIP_TO_END;
  endfunction

  function automatic void parse_byte_reports(char_t c, logic last);
    spec_phase_t ph;
    spec_phase_t r;
    result_t     batch[$];
    ph = spec_phase;
    if (ph != SKIP_TO_END) live_bytes++;
    scan_position = sat_inc(scan_position);
    if (ph == SKIP_TO_END) begin
    end else if (ph == SEEK_TEXT) begin
      ph = (c == CH_PERCENT && !last) ? SAW_PERCENT : SEEK_TEXT;
    end else if (ph == SAW_PERCENT && c == CH_PERCENT) begin
      ph = SEEK_TEXT;
    end else begin
      r = next_phase(ph, c);
      if (r == SPEC_DONE) begin
        spec_total = sat_inc(spec_total);
        batch.push_back(make_report(STATUS_ACCEPT, scan_position));
        ph = SEEK_TEXT;
      end else if (r == SKIP_TO_END || last) begin
        batch.push_back(make_report(STATUS_INVALID, '0));
        ph = SKIP_TO_END;
      end else begin
        ph = r;
      end
    end
    if (last) begin
      if (ph != SKIP_TO_END) batch.push_back(make_report(STATUS_END, scan_position));
      spec_phase = SEEK_TEXT;
      scan_position = '0;
      spec_total = '0;
    end else begin
      spec_phase = ph;
    end
    if (batch.size() > 0) batch[batch.size() - 1].run_last = 1'b1;
    foreach (batch[i]) pending_reports.push_back(batch[i]);
  endfunction

  task automatic send_byte(input char_t c, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.char_byte <= c;
    in_if.is_last <= last;
    do @(posedge clk); while (!in_if.ready);
    parse_byte_reports(c, last);
  endtask

  task automatic send_string(input char_t text[$]);
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  task automatic send_ascii(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(char_t'(s[i]), i == s.len() - 1);
  endtask

  function automatic void add_specifier(ref char_t text[$], input bit broken);
    char_t spec[$];
    char_t extra;
    int    n;
    spec.push_back(CH_PERCENT);
    n = $urandom_range(0, 2);
    repeat (n) spec.push_back(FLAG_CHARS[$urandom_range(0, 4)]);
    n = $urandom_range(0, 2);
    repeat (n) spec.push_back(CH_ZERO + char_t'($urandom_range(0, 9)));
    if ($urandom_range(0, 1)) begin
      spec.push_back(CH_DOT);
      n = $urandom_range(0, 2);
      repeat (n) spec.push_back(CH_ZERO + char_t'($urandom_range(0, 9)));
    end
    n = $urandom_range(0, 2);
    repeat (n) spec.push_back(CH_H);
    n = $urandom_range(0, 2);
    repeat (n) spec.push_back(CH_L);
    if ($urandom_range(0, 2) == 0) spec.push_back(LENGTH_CHARS[$urandom_range(0, 3)]);
    spec.push_back(CH_S);
    if (broken) begin
      case ($urandom_range(0, 4))
        0: spec.insert($urandom_range(1, spec.size() - 1), CH_STAR);
        1: spec.insert($urandom_range(1, spec.size() - 1), char_t'($urandom_range(0, 255)));
        2: void'(spec.pop_back());
        3: spec.insert($urandom_range(1, spec.size() - 1), CH_PERCENT);
        default: begin
          extra = $urandom_range(0, 1) ? CH_H : CH_L;
          repeat (3) spec.insert(spec.size() - 1, extra);
        end
      endcase
    end
    foreach (spec[i]) text.push_back(spec[i]);
  endfunction

  function automatic void build_random_string(ref char_t text[$]);
    int segments;
    int pick;
    int n;
    text.delete();
    segments = $urandom_range(1, 6);
    repeat (segments) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        n = $urandom_range(1, 4);
        repeat (n) text.push_back(char_t'($urandom_range(0, 255)));
      end else if (pick < 45) begin
        text.push_back(CH_PERCENT);
        text.push_back(CH_PERCENT);
      end else if (pick < 88) begin
        add_specifier(text, 1'b0);
      end else begin
        add_specifier(text, 1'b1);
      end
    end
    if ($urandom_range(0, 9) == 0) text.push_back(CH_PERCENT);
  endfunction

  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (pending_reports.size() == 0) begin
          $error("report with no expectation: status %0d, end_position %0d",
                 out_if.status, out_if.end_position);
          fail_count++;
        end else begin
          want = pending_reports.pop_front();
          if (out_if.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_if.status);
            fail_count++;
          end
          if (out_if.end_position !== want.end_position) begin
            $error("end_position: expected %0d, actual %0d",
                   want.end_position, out_if.end_position);
            fail_count++;
          end
          if (out_if.specifier_count !== want.specifier_count) begin
            $error("specifier_count: expected %0d, actual %0d",
                   want.specifier_count, out_if.specifier_count);
            fail_count++;
          end
          if (out_if.run_last !== want.run_last) begin
            $error("run_last: expected %0d, actual %0d", want.run_last, out_if.run_last);
            fail_count++;
          end
        end
      end
    end
  end

  task automatic test_directed();
    gaps_on = 1'b1;
    send_ascii("%s");
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_PERCENT, 1'b1);
    send_ascii("%*q");
    send_ascii("%%%l");
    send_ascii("%-0.9hlts%h%");
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_request = 1'b1;
    repeat (12) begin
      send_byte(CH_PERCENT, 1'b0);
      send_byte(CH_S, 1'b0);
    end
    send_byte(CH_SPACE, 1'b1);
  endtask

  task automatic test_random_strings();
    char_t       text[$];
    int unsigned start;
    start = live_bytes;
    while (live_bytes - start < RANDOM_ITEMS) begin
      build_random_string(text);
      gaps_on = ($urandom_range(0, 7) != 0);
      send_string(text);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.char_byte <= '0;
    in_if.is_last <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_strings();
    in_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fsv_pkg.sv
rtl/fsv_in_if.sv
rtl/fsv_out_if.sv
rtl/format_specifier_validator_unit.sv
verif/tb_format_specifier_validator_unit.sv
